[hw/rtl/mbrw_pkg.sv]
// ----------------------------------------------------------------------------
// mbrw_pkg
// Shared constants, opcodes and helpers for the msb-first bitstream
// reader/writer.
// ----------------------------------------------------------------------------
package mbrw_pkg;

    // Field widths fixed by the stream format
    localparam int OP_W      = 3;
    localparam int IDX_W     = 11;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 6;
    localparam int VAL_W     = 32;
    localparam int OFS_W     = 15;
    localparam int BADDR_W   = OFS_W - 3;

    // Buffer depth default and widest field
    localparam int BUF_BYTES_DEF  = 2048;
    localparam int MAX_FIELD_BITS = 32;

    // Shared shift unit geometry
    localparam int SH_IN_W   = 80;
    localparam int SH_OUT_W  = 40;
    localparam int SH_AMT_W  = 7;

    // Opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_REWIND = 3'd1;
    localparam logic [OP_W-1:0] OP_SKIP   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_SHOW   = 3'd4;
    localparam logic [OP_W-1:0] OP_PUT    = 3'd5;

    // Thermometer mask with the low k bits set, k from 0 to 32
    function automatic logic [VAL_W-1:0] ones32(input logic [CNT_W-1:0] k);
        logic [VAL_W:0] t;
        t = ({{VAL_W{1'b0}}, 1'b1} << k) - {{VAL_W{1'b0}}, 1'b1};
        return t[VAL_W-1:0];
    endfunction

endpackage

[hw/rtl/mbrw_ram.sv]
// ----------------------------------------------------------------------------
// mbrw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mbrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/mbrw_shift.sv]
// ----------------------------------------------------------------------------
// mbrw_shift
// Shared right shifter: aligns read windows, put data and put masks.
// ----------------------------------------------------------------------------
module mbrw_shift (
    input  logic [mbrw_pkg::SH_IN_W-1:0]  din,
    input  logic [mbrw_pkg::SH_AMT_W-1:0] amt,
    output logic [mbrw_pkg::SH_OUT_W-1:0] dout
);
    import mbrw_pkg::*;

    logic [SH_IN_W-1:0] shifted;

    // Shift right and keep the low window
    assign shifted = din >> amt;
    assign dout    = shifted[SH_OUT_W-1:0];

endmodule

[hw/rtl/msb_first_bitstream_reader_writer.sv]
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_writer
// Byte buffer with a bit offset: loads bytes, rewinds, and reads, shows, skips and
// puts fields of up to 32 bits, most significant bit first.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: opcode; tdata: command fields
//  m_*       out  m_tvalid/m_tready   tuser: overrun; tdata: value, remaining
//  cfg_*     in   cfg_valid/cfg_ready cfg_data: bit_length
//
//  Load, rewind, skip, unused opcodes, and any read, show or put that moves
//  no bits (zero count, or overrun on read/show) go straight to the result.
//  Read/show: loop over B spanned bytes (1 to 5) on the single RAM read
//  port, then shift. Put: align data and mask, read and write each byte.
//  One command at a time; s_tready is high only while the sequencer idles.
//  A result waits in the output register; a stalled m_tready holds the
//  sequencer in its final step once a second result is ready.
//  Reset clears offset, length and control; the buffer is not cleared.
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_writer #(
    parameter int BUF_BYTES = mbrw_pkg::BUF_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Command stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [10:0] byte_index, [18:11] byte_value, [24:19] bit_count,
    // [56:25] put_value, [63:57] zero
    input  logic [63:0]                s_tdata,
    // [2:0] opcode
    input  logic [mbrw_pkg::OP_W-1:0]  s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] field_value, [46:32] bits_remaining, [47] zero
    output logic [47:0]                m_tdata,
    // [0] overrun
    output logic [0:0]                 m_tuser,
    // Length register write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mbrw_pkg::OFS_W-1:0] cfg_data
);
    import mbrw_pkg::*;

    localparam int AW       = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
    localparam int CAP_BITS = BUF_BYTES * 8;

    // Sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EVAL = 4'd1;
    localparam logic [3:0] ST_RD   = 4'd2;
    localparam logic [3:0] ST_RSH  = 4'd3;
    localparam logic [3:0] ST_PDAT = 4'd4;
    localparam logic [3:0] ST_PMSK = 4'd5;
    localparam logic [3:0] ST_PRD  = 4'd6;
    localparam logic [3:0] ST_PWR  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    // Control registers
    logic [3:0]         state_reg, state_next;
    logic [OFS_W-1:0]   off_reg, off_next;
    logic [OFS_W-1:0]   blen_reg, blen_next;
    logic [2:0]         k_reg, k_next;
    logic               pend_reg, pend_next;
    logic               mval_reg, mval_next;

    // Payload registers
    logic [OP_W-1:0]    op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [BYTE_W-1:0]  bval_reg, bval_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [VAL_W-1:0]   pval_reg, pval_next;
    logic [CNT_W-1:0]   m_reg, m_next;
    logic [2:0]         s_reg, s_next;
    logic [2:0]         nb_reg, nb_next;
    logic [BADDR_W-1:0] baddr_reg, baddr_next;
    logic [SH_OUT_W-1:0] acc_reg, acc_next;
    logic [SH_OUT_W-1:0] win_reg, win_next;
    logic [SH_OUT_W-1:0] msk_reg, msk_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic               ovr_reg, ovr_next;
    logic [VAL_W-1:0]   fv_reg, fv_next;
    logic [OFS_W-1:0]   rem_reg, rem_next;
    logic               ovo_reg, ovo_next;

    // Datapath signals
    logic [OFS_W-1:0]    len;
    logic [OFS_W:0]      sum;
    logic                ovr_cond;
    logic [CNT_W-1:0]    cnt_in;
    logic [CNT_W-1:0]    put_m;
    logic [CNT_W-1:0]    span;
    logic [BADDR_W-1:0]  loop_addr;
    logic                issue;
    logic                out_free;
    logic [SH_IN_W-1:0]  sh_din;
    logic [SH_AMT_W-1:0] sh_amt;
    logic [SH_OUT_W-1:0] sh_dout;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   mk_byte;

    // Byte buffer
    mbrw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUF_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(loop_addr)),
        .rdata (ram_rdata)
    );

    // Shared alignment shifter
    mbrw_shift u_shift (
        .din  (sh_din),
        .amt  (sh_amt),
        .dout (sh_dout)
    );

    // Handshakes and ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mval_reg;
    assign m_tdata   = {1'b0, rem_reg, fv_reg};
    assign m_tuser   = ovo_reg;
    assign out_free  = !mval_reg || m_tready;

    // Effective length and overrun test
    assign len       = (32'(blen_reg) < CAP_BITS) ? blen_reg : OFS_W'(CAP_BITS);
    assign sum       = {1'b0, off_reg} + (OFS_W+1)'(n_reg);
    assign ovr_cond  = (n_reg != '0) && (sum > {1'b0, len});
    assign put_m     = ovr_cond ? ((off_reg < len) ? CNT_W'(len - off_reg) : '0) : n_reg;
    assign cnt_in    = s_tdata[24:19];
    assign loop_addr = BADDR_W'(baddr_reg + BADDR_W'(k_reg));
    assign issue     = (k_reg < nb_reg);
    assign mk_byte   = msk_reg[SH_OUT_W-1 -: BYTE_W];

    // Shifter operand select
    always_comb
    begin
        sh_din = '0;
        sh_amt = '0;
        case (state_reg)
            ST_RSH:
            begin
                sh_din = {{(SH_IN_W-SH_OUT_W){1'b0}}, acc_reg};
                sh_amt = SH_AMT_W'({nb_reg, 3'b000}) - SH_AMT_W'(s_reg)
                       - SH_AMT_W'(n_reg);
            end
            ST_PDAT:
            begin
                sh_din = {pval_reg, {(SH_IN_W-VAL_W){1'b0}}};
                sh_amt = SH_AMT_W'(8) + SH_AMT_W'(n_reg) + SH_AMT_W'(s_reg);
            end
            ST_PMSK:
            begin
                sh_din = {ones32(m_reg), {(SH_IN_W-VAL_W){1'b0}}};
                sh_amt = SH_AMT_W'(8) + SH_AMT_W'(m_reg) + SH_AMT_W'(s_reg);
            end
            default:
            begin
                sh_din = '0;
                sh_amt = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        off_next   = off_reg;
        blen_next  = blen_reg;
        k_next     = k_reg;
        pend_next  = pend_reg;
        mval_next  = mval_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        bval_next  = bval_reg;
        n_next     = n_reg;
        pval_next  = pval_reg;
        m_next     = m_reg;
        s_next     = s_reg;
        nb_next    = nb_reg;
        baddr_next = baddr_reg;
        acc_next   = acc_reg;
        win_next   = win_reg;
        msk_next   = msk_reg;
        val_next   = val_reg;
        ovr_next   = ovr_reg;
        fv_next    = fv_reg;
        rem_next   = rem_reg;
        ovo_next   = ovo_reg;
        ram_we     = 1'b0;
        ram_waddr  = AW'(loop_addr);
        ram_wdata  = (ram_rdata & ~mk_byte) | (win_reg[SH_OUT_W-1 -: BYTE_W] & mk_byte);
        ram_re     = 1'b0;
        span       = '0;

        // Take a length write
        if (cfg_valid)
        begin
            blen_next = cfg_data;
        end

        // Drop a delivered result
        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the command on transfer
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    idx_next   = s_tdata[10:0];
                    bval_next  = s_tdata[18:11];
                    n_next     = (cnt_in > CNT_W'(MAX_FIELD_BITS)) ?
                                 CNT_W'(MAX_FIELD_BITS) : cnt_in;
                    pval_next  = s_tdata[56:25];
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                val_next   = '0;
                ovr_next   = 1'b0;
                k_next     = '0;
                pend_next  = 1'b0;
                s_next     = off_reg[2:0];
                baddr_next = off_reg[OFS_W-1:3];
                state_next = ST_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        ram_waddr = AW'(idx_reg);
                        ram_wdata = bval_reg;
                        ram_we    = (32'(idx_reg) < BUF_BYTES);
                    end
                    OP_REWIND:
                    begin
                        off_next = '0;
                    end
                    OP_SKIP:
                    begin
                        if (sum > {1'b0, len})
                        begin
                            off_next = (off_reg > len) ? off_reg : len;
                        end
                        else
                        begin
                            off_next = sum[OFS_W-1:0];
                        end
                    end
                    OP_READ, OP_SHOW:
                    begin
                        if (ovr_cond)
                        begin
                            ovr_next = 1'b1;
                            if (op_reg == OP_READ && off_reg < len)
                            begin
                                off_next = len;
                            end
                        end
                        else if (n_reg != '0)
                        begin
                            span    = CNT_W'(off_reg[2:0]) + n_reg + CNT_W'(7);
                            nb_next = span[CNT_W-1:3];
                            if (op_reg == OP_READ)
                            begin
                                off_next = sum[OFS_W-1:0];
                            end
                            state_next = ST_RD;
                        end
                    end
                    OP_PUT:
                    begin
                        ovr_next = ovr_cond;
                        m_next   = put_m;
                        if (put_m != '0)
                        begin
                            span       = CNT_W'(off_reg[2:0]) + put_m + CNT_W'(7);
                            nb_next    = span[CNT_W-1:3];
                            off_next   = OFS_W'(off_reg + OFS_W'(put_m));
                            state_next = ST_PDAT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_RD:
            begin
                // Issue byte reads and shift in the returned bytes
                ram_re    = issue;
                pend_next = issue;
                if (issue)
                begin
                    k_next = 3'(k_reg + 3'd1);
                end
                if (pend_reg)
                begin
                    acc_next = {acc_reg[SH_OUT_W-BYTE_W-1:0], ram_rdata};
                end
                if (!issue)
                begin
                    state_next = ST_RSH;
                end
            end

            ST_RSH:
            begin
                val_next   = sh_dout[VAL_W-1:0] & ones32(n_reg);
                state_next = ST_DONE;
            end

            ST_PDAT:
            begin
                win_next   = sh_dout;
                state_next = ST_PMSK;
            end

            ST_PMSK:
            begin
                msk_next   = sh_dout;
                state_next = ST_PRD;
            end

            ST_PRD:
            begin
                ram_re     = 1'b1;
                state_next = ST_PWR;
            end

            ST_PWR:
            begin
                // Merge the put bits into the old byte and advance
                ram_we   = 1'b1;
                k_next   = 3'(k_reg + 3'd1);
                win_next = win_reg << BYTE_W;
                msk_next = msk_reg << BYTE_W;
                if (3'(k_reg + 3'd1) == nb_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_PRD;
                end
            end

            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    fv_next    = val_reg;
                    rem_next   = (off_reg < len) ? OFS_W'(len - off_reg) : '0;
                    ovo_next   = ovr_reg;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            off_reg   <= '0;
            blen_reg  <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            blen_reg  <= blen_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
            mval_reg  <= mval_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        idx_reg   <= idx_next;
        bval_reg  <= bval_next;
        n_reg     <= n_next;
        pval_reg  <= pval_next;
        m_reg     <= m_next;
        s_reg     <= s_next;
        nb_reg    <= nb_next;
        baddr_reg <= baddr_next;
        acc_reg   <= acc_next;
        win_reg   <= win_next;
        msk_reg   <= msk_next;
        val_reg   <= val_next;
        ovr_reg   <= ovr_next;
        fv_reg    <= fv_next;
        rem_reg   <= rem_next;
        ovo_reg   <= ovo_next;
    end

`ifndef NO_ASSERTIONS
    // A transfer always starts evaluation next cycle
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EVAL))
        else $error("command transfer did not start evaluation");

    // The put loop never runs past the spanned bytes
    a_put_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PWR) |-> (k_reg < nb_reg))
        else $error("put loop beyond spanned bytes");

    // The read loop spans one to five bytes
    a_read_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (nb_reg != 3'd0 && nb_reg <= 3'd5))
        else $error("read span out of range");

    // A new result only comes from the final step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mval_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside final step");
`endif

endmodule
